[src/chxy_pkg.sv]
`timescale 1ns / 1ps
// Package for the compass heading block: transaction types, pipeline context and
// the sine/cosine comparison tables built at elaboration. Depends on nothing.
package chxy_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int WORK_BITS       = ANGLE_FRAC_BITS + 36;
   localparam int CMP_BITS        = 48;
   localparam int SERIES_TERMS    = 14;
   localparam int unsigned DEG_HALF = 180;
   localparam int unsigned DEG_FULL = 360;
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   localparam int NUM_DEG      = 90;
   localparam int SEARCH_STEPS = 7;
   localparam int IDX_W        = 7;
   localparam int MAG_W        = 16;
   localparam int PROD_W       = MAG_W + CMP_BITS;
   localparam int HEAD_W       = 9;

   localparam logic [IDX_W-1:0]  SEARCH_LAST = IDX_W'(NUM_DEG - 1);
   localparam logic [IDX_W-1:0]  FL_X_ZERO   = IDX_W'(90);
   localparam logic [IDX_W-1:0]  FL_DIAG     = IDX_W'(45);
   localparam logic [HEAD_W-1:0] HEAD_HALF   = HEAD_W'(DEG_HALF);
   localparam logic [HEAD_W-1:0] HEAD_FULL   = HEAD_W'(DEG_FULL);

   typedef struct packed {
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
   } req_type;

   typedef struct packed {
      logic [8:0] heading_deg;
      logic [1:0] digit_hundreds;
      logic [3:0] digit_tens;
      logic [3:0] digit_ones;
   } rsp_type;

   // How the floor angle within the quadrant is found.
   typedef enum logic [1:0] {
      CLS_ORIGIN,
      CLS_X_ZERO,
      CLS_DIAG,
      CLS_SEARCH
   } cls_type;

   typedef struct packed {
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic             xneg;
      logic             yneg;
      cls_type          cls;
      logic             exact;
      logic [IDX_W-1:0] pos;
   } ctx_type;

   typedef struct packed {
      logic    valid;
      ctx_type ctx;
   } stage_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } fin_type;

   typedef logic [CMP_BITS-1:0] tab_type [NUM_DEG];

   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[WORK_BITS+63:WORK_BITS];
   endfunction

   // Term n of the series divides by (2n)(2n+1) for sine and (2n-1)(2n) for cosine.
   function automatic logic [63:0] series_div(input logic [63:0] v, input int n,
                                              input logic want_sin);
      logic [63:0] q;
      q = v;
      case (n)
         1:       q = want_sin ? v / 64'd6   : v / 64'd2;
         2:       q = want_sin ? v / 64'd20  : v / 64'd12;
         3:       q = want_sin ? v / 64'd42  : v / 64'd30;
         4:       q = want_sin ? v / 64'd72  : v / 64'd56;
         5:       q = want_sin ? v / 64'd110 : v / 64'd90;
         6:       q = want_sin ? v / 64'd156 : v / 64'd132;
         7:       q = want_sin ? v / 64'd210 : v / 64'd182;
         8:       q = want_sin ? v / 64'd272 : v / 64'd240;
         9:       q = want_sin ? v / 64'd342 : v / 64'd306;
         10:      q = want_sin ? v / 64'd420 : v / 64'd380;
         11:      q = want_sin ? v / 64'd506 : v / 64'd462;
         12:      q = want_sin ? v / 64'd600 : v / 64'd552;
         13:      q = want_sin ? v / 64'd702 : v / 64'd650;
         14:      q = want_sin ? v / 64'd812 : v / 64'd756;
         default: q = v;
      endcase
      return q;
   endfunction

   // Entry 0 is read only for an out-of-range candidate, whose test is forced to fail; it is left at zero.
   function automatic tab_type build_tab(input logic want_sin);
      tab_type     t;
      logic [63:0] piw;
      logic [63:0] one;
      logic [63:0] rad;
      logic [63:0] r2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] tmp;
      int          d;
      int          n;
      piw  = PI_Q60 >> (60 - WORK_BITS);
      one  = 64'd1 << WORK_BITS;
      t[0] = '0;
      for (d = 1; d < NUM_DEG; d++) begin
         rad  = (piw / DEG_HALF) * 64'(d) + ((piw % DEG_HALF) * 64'(d)) / DEG_HALF;
         r2   = fx_mul(rad, rad);
         term = want_sin ? rad : one;
         sum  = term;
         for (n = 1; n <= SERIES_TERMS; n++) begin
            term = series_div(fx_mul(term, r2), n, want_sin);
            if (n[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tmp  = sum >> (WORK_BITS - CMP_BITS);
         t[d] = tmp[CMP_BITS-1:0];
      end
      return t;
   endfunction

   localparam tab_type SIN_TAB = build_tab(1'b1);
   localparam tab_type COS_TAB = build_tab(1'b0);

endpackage

[src/chxy_search_step.sv]
`timescale 1ns / 1ps
// One step of the binary search for the floor degree: a multiply stage and a
// compare stage. Depends on chxy_pkg for the context type and the tables.
module chxy_search_step #(
   parameter int STEP_BIT = chxy_pkg::SEARCH_STEPS - 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  chxy_pkg::stage_type stage_in,
   output chxy_pkg::stage_type stage_out
);

   localparam logic [chxy_pkg::IDX_W-1:0] STEP_MASK = chxy_pkg::IDX_W'(1) << STEP_BIT;

   logic [chxy_pkg::IDX_W-1:0]  cand;
   logic                        cand_ok;
   logic [chxy_pkg::IDX_W-1:0]  idx;
   logic [chxy_pkg::PROD_W-1:0] prod_c_in;
   logic [chxy_pkg::PROD_W-1:0] prod_s_in;

   logic                        a_valid_ff;
   chxy_pkg::ctx_type           a_ctx_ff;
   logic [chxy_pkg::IDX_W-1:0]  a_cand_ff;
   logic                        a_ok_ff;
   logic [chxy_pkg::PROD_W-1:0] a_prod_c_ff;
   logic [chxy_pkg::PROD_W-1:0] a_prod_s_ff;

   logic                        pass;
   chxy_pkg::ctx_type           b_ctx_in;
   logic                        b_valid_ff;
   chxy_pkg::ctx_type           b_ctx_ff;

   // Lower bits of pos are still zero here, so setting this step's bit adds it.
   assign cand    = stage_in.ctx.pos | STEP_MASK;
   assign cand_ok = (cand <= chxy_pkg::SEARCH_LAST);
   assign idx     = cand_ok ? cand : '0;

   assign prod_c_in = {{chxy_pkg::CMP_BITS{1'b0}}, stage_in.ctx.ay} *
                      {{chxy_pkg::MAG_W{1'b0}}, chxy_pkg::COS_TAB[idx]};
   assign prod_s_in = {{chxy_pkg::CMP_BITS{1'b0}}, stage_in.ctx.ax} *
                      {{chxy_pkg::MAG_W{1'b0}}, chxy_pkg::SIN_TAB[idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ctx_ff    <= stage_in.ctx;
         a_cand_ff   <= cand;
         a_ok_ff     <= cand_ok;
         a_prod_c_ff <= prod_c_in;
         a_prod_s_ff <= prod_s_in;
      end
   end

   // The test holds for every degree up to the floor angle and fails above it.
   assign pass = a_ok_ff && (a_prod_c_ff >= a_prod_s_ff);

   always_comb begin
      b_ctx_in = a_ctx_ff;
      if (pass) begin
         b_ctx_in.pos = a_cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_ctx_ff <= b_ctx_in;
      end
   end

   assign stage_out.valid = b_valid_ff;
   assign stage_out.ctx   = b_ctx_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_ctx_ff.pos <= chxy_pkg::SEARCH_LAST))
      else $error("search position beyond the last degree");

   a_pos_grows: assert property (@(posedge clock) disable iff (reset)
      (enable && a_valid_ff) |=> (b_ctx_ff.pos >= $past(a_ctx_ff.pos)))
      else $error("search position moved backward");

endmodule

[src/chxy_finish.sv]
`timescale 1ns / 1ps
// Folds the quadrant floor angle into a 0..359 heading and splits it into decimal
// digits over three register stages. Depends on chxy_pkg.
module chxy_finish (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  chxy_pkg::stage_type stage_in,
   output chxy_pkg::fin_type   fin_out
);

   localparam logic [7:0] TENS_RECIP = 8'd205;
   localparam int         TENS_SHIFT = 11;

   logic [chxy_pkg::IDX_W-1:0]  fl;
   logic [chxy_pkg::HEAD_W-1:0] fl9;
   logic [chxy_pkg::HEAD_W-1:0] back9;
   logic [chxy_pkg::HEAD_W-1:0] h_head_in;
   logic                        h_valid_ff;
   logic [chxy_pkg::HEAD_W-1:0] h_head_ff;

   logic [1:0]                  d_hund_in;
   logic [chxy_pkg::HEAD_W-1:0] d_base;
   logic [chxy_pkg::HEAD_W-1:0] d_diff;
   logic                        d_valid_ff;
   logic [chxy_pkg::HEAD_W-1:0] d_head_ff;
   logic [1:0]                  d_hund_ff;
   logic [6:0]                  d_rem_ff;

   logic [14:0]                 tens_prod;
   logic [3:0]                  tens;
   logic [6:0]                  ones_diff;
   logic                        o_valid_ff;
   chxy_pkg::rsp_type           o_rsp_ff;

   always_comb begin
      case (stage_in.ctx.cls)
         chxy_pkg::CLS_ORIGIN: fl = '0;
         chxy_pkg::CLS_X_ZERO: fl = chxy_pkg::FL_X_ZERO;
         chxy_pkg::CLS_DIAG:   fl = chxy_pkg::FL_DIAG;
         default:              fl = stage_in.ctx.pos;
      endcase
   end

   // Off the axes and diagonals the true angle lies strictly inside a degree,
   // so reflected quadrants step back one more degree.
   assign fl9   = {{(chxy_pkg::HEAD_W - chxy_pkg::IDX_W){1'b0}}, fl};
   assign back9 = {{(chxy_pkg::HEAD_W - 1){1'b0}}, ~stage_in.ctx.exact};

   always_comb begin
      if (!stage_in.ctx.xneg) begin
         h_head_in = stage_in.ctx.yneg ? (chxy_pkg::HEAD_FULL - fl9 - back9) : fl9;
      end else begin
         h_head_in = stage_in.ctx.yneg ? (chxy_pkg::HEAD_HALF + fl9)
                                       : (chxy_pkg::HEAD_HALF - fl9 - back9);
      end
   end

   always_comb begin
      if (h_head_ff >= 9'd300) begin
         d_hund_in = 2'd3;
         d_base    = 9'd300;
      end else if (h_head_ff >= 9'd200) begin
         d_hund_in = 2'd2;
         d_base    = 9'd200;
      end else if (h_head_ff >= 9'd100) begin
         d_hund_in = 2'd1;
         d_base    = 9'd100;
      end else begin
         d_hund_in = 2'd0;
         d_base    = 9'd0;
      end
      d_diff = h_head_ff - d_base;
   end

   // A remainder below 100 divides by ten through the reciprocal 205 / 2048.
   assign tens_prod = {8'd0, d_rem_ff} * {7'd0, TENS_RECIP};
   assign tens      = tens_prod[TENS_SHIFT+3:TENS_SHIFT];
   assign ones_diff = d_rem_ff - ({3'd0, tens} * 7'd10);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         h_valid_ff <= stage_in.valid;
         d_valid_ff <= h_valid_ff;
         o_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         h_head_ff               <= h_head_in;
         d_head_ff               <= h_head_ff;
         d_hund_ff               <= d_hund_in;
         d_rem_ff                <= d_diff[6:0];
         o_rsp_ff.heading_deg    <= d_head_ff;
         o_rsp_ff.digit_hundreds <= d_hund_ff;
         o_rsp_ff.digit_tens     <= tens;
         o_rsp_ff.digit_ones     <= ones_diff[3:0];
      end
   end

   assign fin_out.valid = o_valid_ff;
   assign fin_out.rsp   = o_rsp_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (d_rem_ff < 7'd100))
      else $error("hundreds split left a remainder above 99");

endmodule

[src/compass_heading_from_xy.sv]
`timescale 1ns / 1ps
// Top level of the compass heading block: input stage, seven search steps, the
// finishing stages and the output register with skid. Depends on chxy_pkg,
// chxy_search_step and chxy_finish.
//
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_stall  chxy_pkg::req_type (x_value, y_value)
// rsp      out  rsp_valid / rsp_stall  chxy_pkg::rsp_type (heading and digits)
//
// One transaction per cycle sustained while the output does not stall. Most of
// the pipeline depth comes from the seven-step binary search over the degree
// table, each step a multiply stage and a compare stage. Reset clears only the
// valid bits. A stalled output transaction holds in the output register, the one
// behind it drops into a skid register, and req_stall is that skid register's
// full flag.
module compass_heading_from_xy (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  chxy_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chxy_pkg::rsp_type rsp_data
);

   logic                         enable;
   logic [chxy_pkg::MAG_W-1:0]   xr;
   logic [chxy_pkg::MAG_W-1:0]   yr;
   chxy_pkg::ctx_type            s0_ctx_in;
   logic                         s0_valid_ff;
   chxy_pkg::ctx_type            s0_ctx_ff;

   chxy_pkg::stage_type          link [chxy_pkg::SEARCH_STEPS+1];
   chxy_pkg::fin_type            fin;

   logic                         out_load;
   logic                         rsp_valid_in;
   logic                         rsp_valid_ff;
   chxy_pkg::rsp_type            rsp_data_in;
   chxy_pkg::rsp_type            rsp_data_ff;
   logic                         skid_full_in;
   logic                         skid_full_ff;
   chxy_pkg::rsp_type            skid_data_in;
   chxy_pkg::rsp_type            skid_data_ff;

   assign enable    = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Magnitudes are taken on 16 bits; -32768 comes out as 32768.
   assign xr = req_data.x_value;
   assign yr = req_data.y_value;

   always_comb begin
      s0_ctx_in.xneg = xr[chxy_pkg::MAG_W-1];
      s0_ctx_in.yneg = yr[chxy_pkg::MAG_W-1];
      s0_ctx_in.ax   = s0_ctx_in.xneg ? ('0 - xr) : xr;
      s0_ctx_in.ay   = s0_ctx_in.yneg ? ('0 - yr) : yr;
      s0_ctx_in.pos  = '0;
      s0_ctx_in.exact = (s0_ctx_in.ax == '0) || (s0_ctx_in.ay == '0) ||
                        (s0_ctx_in.ax == s0_ctx_in.ay);
      if (s0_ctx_in.ax == '0 && s0_ctx_in.ay == '0) begin
         s0_ctx_in.cls = chxy_pkg::CLS_ORIGIN;
      end else if (s0_ctx_in.ax == '0) begin
         s0_ctx_in.cls = chxy_pkg::CLS_X_ZERO;
      end else if (s0_ctx_in.ax == s0_ctx_in.ay) begin
         s0_ctx_in.cls = chxy_pkg::CLS_DIAG;
      end else begin
         s0_ctx_in.cls = chxy_pkg::CLS_SEARCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_ctx_ff <= s0_ctx_in;
      end
   end

   assign link[0].valid = s0_valid_ff;
   assign link[0].ctx   = s0_ctx_ff;

   // The search settles the position bit by bit, most significant first.
   for (genvar i = 0; i < chxy_pkg::SEARCH_STEPS; i++) begin : g_step
      chxy_search_step #(
         .STEP_BIT(chxy_pkg::SEARCH_STEPS - 1 - i)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .stage_in (link[i]),
         .stage_out(link[i+1])
      );
   end

   chxy_finish u_finish (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .stage_in(link[chxy_pkg::SEARCH_STEPS]),
      .fin_out (fin)
   );

   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_full_in = skid_full_ff;
      skid_data_in = skid_data_ff;
      if (out_load) begin
         if (skid_full_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = skid_data_ff;
            skid_full_in = 1'b0;
         end else begin
            rsp_valid_in = fin.valid;
            rsp_data_in  = fin.rsp;
         end
      end else if (!skid_full_ff && fin.valid) begin
         skid_full_in = 1'b1;
         skid_data_in = fin.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid register holds a transaction while the output is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && fin.valid && !skid_full_ff) |=> skid_full_ff)
      else $error("pipeline output lost while the result channel stalled");

   a_digits_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.heading_deg ==
         ({7'd0, rsp_data_ff.digit_hundreds} * 9'd100) +
         ({5'd0, rsp_data_ff.digit_tens} * 9'd10) + {5'd0, rsp_data_ff.digit_ones}))
      else $error("decimal digits disagree with the heading");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.heading_deg < chxy_pkg::HEAD_FULL))
      else $error("heading outside 0 to 359");

endmodule
